// ----- sv/scca_pkg.sv -----
// Shared types and constants of the size-class chunk allocator.
package scca_pkg;

  localparam int SIZE_W      = 17;  // byte counts, class sizes, pool size
  localparam int OFF_W       = 16;  // pool byte offsets
  localparam int CLS_W       = 2;   // size class index
  localparam int STAT_W      = 3;
  localparam int ALIGN_W     = 4;
  localparam int NUM_CLASSES = 4;
  localparam int AL_W        = SIZE_W + 1;  // aligned start and chunk end
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = SIZE_W;

  localparam logic [SIZE_W-1:0] POOL_CAP = SIZE_W'(1) << OFF_W;

  // Commands
  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  // Result status codes
  localparam logic [STAT_W-1:0] ST_OK         = 3'd0;
  localparam logic [STAT_W-1:0] ST_NO_CLASS   = 3'd1;
  localparam logic [STAT_W-1:0] ST_POOL_EXH   = 3'd2;
  localparam logic [STAT_W-1:0] ST_TABLE_FULL = 3'd3;
  localparam logic [STAT_W-1:0] ST_NOT_FOUND  = 3'd4;
  localparam logic [STAT_W-1:0] ST_ALREADY    = 3'd5;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CLASS0 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CLASS1 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CLASS2 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CLASS3 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ALIGN  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_POOL   = 3'd5;

  localparam logic [ALIGN_W-1:0] ALIGN_RST = 4'd3;

  typedef struct packed {
    logic              cmd;
    logic [SIZE_W-1:0] req_bytes;
    logic [OFF_W-1:0]  free_offset;
  } in_beat_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [OFF_W-1:0]  chunk_offset;
    logic [CLS_W-1:0]  class_index;
  } out_beat_t;

  // One chunk table entry
  typedef struct packed {
    logic [OFF_W-1:0] off;
    logic [CLS_W-1:0] cls;
    logic             is_free;
  } ent_t;

  // Class selection result
  typedef struct packed {
    logic              found;
    logic [CLS_W-1:0]  idx;
    logic [SIZE_W-1:0] size;
  } cls_sel_t;

  typedef logic [NUM_CLASSES-1:0][SIZE_W-1:0] class_sizes_t;

endpackage

// ----- sv/size_class_chunk_allocator_top.sv -----
// Top level of the size-class chunk allocator: control, chunk table memory, config.
//
// Segregated-fit pool allocator. Each input beat is an allocate of req_bytes or a
// free of free_offset, and yields exactly one result beat. An allocate picks the
// smallest nonzero class that holds the request, reuses that class's free chunk
// with the lowest offset, and otherwise carves a new chunk from a bump pointer
// aligned to 2^align_log2, if it fits below min(pool_bytes, 64 KiB) and the chunk
// table has room. A free marks a recorded chunk free, or reports it unknown or
// already free. The chunk table is a single-port-read synchronous RAM of
// MAX_ENTRIES words that is scanned one entry per cycle. The next beat can be taken
// in the cycle after the result is loaded. A result waits in an output register,
// so the next request is accepted while it is still pending; that request then
// holds in its decide step until the output register frees up. No clearing pass
// is needed: only entries below entry_count are ever read. Config registers must
// be written only while the block is idle; the block itself does not enforce
// this.
module size_class_chunk_allocator_top
  import scca_pkg::*;
#(
  parameter int MAX_ENTRIES = 64
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // request channel
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_beat_t              in_data,
  // result channel
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_beat_t             out_data,
  // config write port
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int AW    = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

  // FSM codes
  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCAN   = 2'd1;
  localparam logic [1:0] S_DECIDE = 2'd2;

  // ---------------- config registers ----------------
  class_sizes_t       class_size_r;
  logic [ALIGN_W-1:0] align_log2_r;
  logic [SIZE_W-1:0]  pool_bytes_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      class_size_r <= '0;
      align_log2_r <= ALIGN_RST;
      pool_bytes_r <= POOL_CAP;
    end else if (cfg_we) begin
      unique case (cfg_index) inside
        REG_CLASS0, REG_CLASS1, REG_CLASS2, REG_CLASS3:
          class_size_r[cfg_index[CLS_W-1:0]] <= cfg_wdata;
        REG_ALIGN: align_log2_r <= cfg_wdata[ALIGN_W-1:0];
        REG_POOL:  pool_bytes_r <= cfg_wdata;
        default: ;  // unmapped index: ignored
      endcase
    end
  end

  // ---------------- class selection ----------------
  cls_sel_t sel;

  scca_class_sel u_class_sel (
    .class_size (class_size_r),
    .req_bytes  (in_data.req_bytes),
    .sel        (sel)
  );

  // ---------------- state ----------------
  logic [1:0]        state_r, state_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [SIZE_W-1:0] bump_r, bump_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_beat_t         out_r, out_nxt;

  // per-item working registers
  logic              cmd_r, cmd_nxt;
  logic [OFF_W-1:0]  foff_r, foff_nxt;
  logic              cls_ok_r, cls_ok_nxt;
  logic [CLS_W-1:0]  best_idx_r, best_idx_nxt;
  logic [SIZE_W-1:0] best_size_r, best_size_nxt;
  logic [CNT_W-1:0]  rd_idx_r, rd_idx_nxt;
  logic              cmp_vld_r, cmp_vld_nxt;
  logic [AW-1:0]     cmp_idx_r, cmp_idx_nxt;
  logic              hit_vld_r, hit_vld_nxt;
  logic [AW-1:0]     hit_idx_r, hit_idx_nxt;
  ent_t              hit_ent_r, hit_ent_nxt;
  logic [AL_W-1:0]   aligned_r, aligned_nxt;
  logic [SIZE_W-1:0] limit_r, limit_nxt;
  logic              over_r, over_nxt;

  // chunk table memory
  ent_t              mem [MAX_ENTRIES];
  ent_t              rd_data_r;
  logic              rd_en;
  logic [AW-1:0]     rd_addr;
  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  ent_t              wr_data;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_data_r <= mem[rd_addr];
  end

  // ---------------- control ----------------
  logic            out_slot_free;
  logic [AL_W-1:0] amask;
  logic [AL_W-1:0] chunk_end;
  logic            pool_bad;
  logic            tbl_full;

  assign out_slot_free = !out_valid_r || out_ready;
  assign amask     = (AL_W'(1) << align_log2_r) - AL_W'(1);
  assign chunk_end = aligned_r + AL_W'(best_size_r);
  assign pool_bad  = over_r || (chunk_end > AL_W'(limit_r));
  assign tbl_full  = (count_r == CNT_W'(MAX_ENTRIES));

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    bump_nxt      = bump_r;
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    cmd_nxt       = cmd_r;
    foff_nxt      = foff_r;
    cls_ok_nxt    = cls_ok_r;
    best_idx_nxt  = best_idx_r;
    best_size_nxt = best_size_r;
    rd_idx_nxt    = rd_idx_r;
    cmp_vld_nxt   = 1'b0;
    cmp_idx_nxt   = cmp_idx_r;
    hit_vld_nxt   = hit_vld_r;
    hit_idx_nxt   = hit_idx_r;
    hit_ent_nxt   = hit_ent_r;
    aligned_nxt   = aligned_r;
    limit_nxt     = limit_r;
    over_nxt      = over_r;
    rd_en         = 1'b0;
    rd_addr       = rd_idx_r[AW-1:0];
    wr_en         = 1'b0;
    wr_addr       = hit_idx_r;
    wr_data       = hit_ent_r;

    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd_nxt       = in_data.cmd;
          foff_nxt      = in_data.free_offset;
          cls_ok_nxt    = sel.found;
          best_idx_nxt  = sel.idx;
          best_size_nxt = sel.size;
          rd_idx_nxt    = '0;
          hit_vld_nxt   = 1'b0;
          // no class fits: nothing to scan
          state_nxt = (in_data.cmd == CMD_ALLOC && !sel.found) ? S_DECIDE : S_SCAN;
        end
      end

      S_SCAN: begin
        // carve candidate, settles while the table is scanned
        aligned_nxt = (AL_W'(bump_r) + amask) & ~amask;
        limit_nxt   = (pool_bytes_r > POOL_CAP) ? POOL_CAP : pool_bytes_r;
        over_nxt    = (bump_r >= limit_nxt);

        // read one entry per cycle
        if (rd_idx_r < count_r) begin
          rd_en       = 1'b1;
          rd_idx_nxt  = rd_idx_r + CNT_W'(1);
          cmp_vld_nxt = 1'b1;
          cmp_idx_nxt = rd_idx_r[AW-1:0];
        end

        // compare the entry read last cycle
        if (cmp_vld_r) begin
          if (cmd_r == CMD_ALLOC) begin
            if (rd_data_r.cls == best_idx_r && rd_data_r.is_free &&
                (!hit_vld_r || rd_data_r.off < hit_ent_r.off)) begin
              hit_vld_nxt = 1'b1;
              hit_idx_nxt = cmp_idx_r;
              hit_ent_nxt = rd_data_r;
            end
          end else if (!hit_vld_r && rd_data_r.off == foff_r) begin
            hit_vld_nxt = 1'b1;
            hit_idx_nxt = cmp_idx_r;
            hit_ent_nxt = rd_data_r;
          end
        end

        if (rd_idx_r == count_r && !cmp_vld_r) state_nxt = S_DECIDE;
      end

      S_DECIDE: begin
        // all updates happen together with loading the result
        if (out_slot_free) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
          out_nxt       = '0;
          if (cmd_r == CMD_ALLOC) begin
            if (!cls_ok_r) begin
              out_nxt.status = ST_NO_CLASS;
            end else if (hit_vld_r) begin
              out_nxt.status       = ST_OK;
              out_nxt.chunk_offset = hit_ent_r.off;
              out_nxt.class_index  = best_idx_r;
              wr_en           = 1'b1;
              wr_data         = hit_ent_r;
              wr_data.is_free = 1'b0;
            end else if (pool_bad) begin
              out_nxt.status = ST_POOL_EXH;
            end else if (tbl_full) begin
              out_nxt.status = ST_TABLE_FULL;
            end else begin
              out_nxt.status       = ST_OK;
              out_nxt.chunk_offset = aligned_r[OFF_W-1:0];
              out_nxt.class_index  = best_idx_r;
              wr_en           = 1'b1;
              wr_addr         = count_r[AW-1:0];
              wr_data.off     = aligned_r[OFF_W-1:0];
              wr_data.cls     = best_idx_r;
              wr_data.is_free = 1'b0;
              count_nxt       = count_r + CNT_W'(1);
              bump_nxt        = chunk_end[SIZE_W-1:0];
            end
          end else begin
            if (hit_vld_r) begin
              out_nxt.chunk_offset = hit_ent_r.off;
              out_nxt.class_index  = hit_ent_r.cls;
              if (hit_ent_r.is_free) begin
                out_nxt.status = ST_ALREADY;
              end else begin
                out_nxt.status  = ST_OK;
                wr_en           = 1'b1;
                wr_data         = hit_ent_r;
                wr_data.is_free = 1'b1;
              end
            end else begin
              out_nxt.status = ST_NOT_FOUND;
            end
          end
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      bump_r      <= '0;
      out_valid_r <= 1'b0;
      rd_idx_r    <= '0;
      cmp_vld_r   <= 1'b0;
      hit_vld_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      bump_r      <= bump_nxt;
      out_valid_r <= out_valid_nxt;
      rd_idx_r    <= rd_idx_nxt;
      cmp_vld_r   <= cmp_vld_nxt;
      hit_vld_r   <= hit_vld_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    out_r       <= out_nxt;
    cmd_r       <= cmd_nxt;
    foff_r      <= foff_nxt;
    cls_ok_r    <= cls_ok_nxt;
    best_idx_r  <= best_idx_nxt;
    best_size_r <= best_size_nxt;
    cmp_idx_r   <= cmp_idx_nxt;
    hit_idx_r   <= hit_idx_nxt;
    hit_ent_r   <= hit_ent_nxt;
    aligned_r   <= aligned_nxt;
    limit_r     <= limit_nxt;
    over_r      <= over_nxt;
  end

endmodule

// ----- sv/scca_class_sel.sv -----
// Smallest-fit size class selection for an allocate request.
module scca_class_sel
  import scca_pkg::*;
(
  input  class_sizes_t      class_size,
  input  logic [SIZE_W-1:0] req_bytes,
  output cls_sel_t          sel
);

  // Strict compare keeps the lowest index among equal sizes.
  always_comb begin
    sel = '0;
    for (int k = 0; k < NUM_CLASSES; k++) begin
      if (class_size[k] != '0 && req_bytes <= class_size[k] &&
          (!sel.found || class_size[k] < sel.size)) begin
        sel.found = 1'b1;
        sel.idx   = CLS_W'(k);
        sel.size  = class_size[k];
      end
    end
  end

endmodule

// ----- sv/scca_checker.sv -----
// Port-level checks for the size-class chunk allocator, bound to the top level.
module scca_checker
  import scca_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_valid,
  input logic                  in_ready,
  input logic                  out_valid,
  input logic                  out_ready,
  input out_beat_t             out_data
);

  // status code stays within the defined set
  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.status <= ST_ALREADY)
    else $error("result status out of range");

  // failed allocates and unknown frees carry zero offset and class
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status == ST_NO_CLASS || out_data.status == ST_POOL_EXH ||
                  out_data.status == ST_TABLE_FULL || out_data.status == ST_NOT_FOUND)
    |-> out_data.chunk_offset == '0 && out_data.class_index == '0)
    else $error("failed result with nonzero offset or class");

  // one request at a time: no accept right after an accept
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted while previous still in work");

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result beat dropped or changed under stall");

endmodule

bind size_class_chunk_allocator_top scca_checker u_scca_checker (.*);

// ----- dv/size_class_chunk_allocator_top_tb.sv -----
// Self-checking testbench of the size-class chunk allocator: tracker class and top module.
`timescale 1ns / 1ps

import scca_pkg::*;

class chunk_alloc_tracker #(int DEPTH = 64);
  logic [SIZE_W-1:0]  class_size [NUM_CLASSES];
  logic [ALIGN_W-1:0] align_log2;
  logic [SIZE_W-1:0]  pool_bytes;
  logic [SIZE_W-1:0]  bump;
  int unsigned        n_chunks;
  ent_t               chunks [DEPTH];
  out_beat_t          due_results [$];
  int                 errors;

  function new();
    foreach (class_size[k]) class_size[k] = '0;
    align_log2 = ALIGN_RST;
    pool_bytes = POOL_CAP;
    bump       = '0;
    n_chunks   = 0;
    errors     = 0;
  endfunction

  function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    case (idx)
      REG_CLASS0: class_size[0] = val;
      REG_CLASS1: class_size[1] = val;
      REG_CLASS2: class_size[2] = val;
      REG_CLASS3: class_size[3] = val;
      REG_ALIGN:  align_log2 = val[ALIGN_W-1:0];
      REG_POOL:   pool_bytes = val;
      default: ;
    endcase
  endfunction

  // Applies one request to the tracked table and returns the result it must give.
  function out_beat_t serve_request(in_beat_t b);
    out_beat_t         r;
    int                best;
    int                hit;
    logic [SIZE_W-1:0] best_sz;
    logic [AL_W-1:0]   lim;
    logic [AL_W-1:0]   step;
    logic [AL_W-1:0]   start;
    r       = '0;
    best    = -1;
    hit     = -1;
    best_sz = '0;
    if (b.cmd == CMD_FREE) begin
      for (int i = 0; i < n_chunks; i++) begin
        if (chunks[i].off == b.free_offset) begin
          r.status       = chunks[i].is_free ? ST_ALREADY : ST_OK;
          r.chunk_offset = b.free_offset;
          r.class_index  = chunks[i].cls;
          chunks[i].is_free = 1'b1;
          return r;
        end
      end
      r.status = ST_NOT_FOUND;
      return r;
    end
    // smallest nonzero class that holds the request, lowest index on a tie
    for (int k = 0; k < NUM_CLASSES; k++) begin
      if (class_size[k] != '0 && b.req_bytes <= class_size[k] &&
          (best < 0 || class_size[k] < best_sz)) begin
        best    = k;
        best_sz = class_size[k];
      end
    end
    if (best < 0) begin
      r.status = ST_NO_CLASS;
      return r;
    end
    for (int i = 0; i < n_chunks; i++) begin
      if (chunks[i].cls == CLS_W'(best) && chunks[i].is_free &&
          (hit < 0 || chunks[i].off < chunks[hit].off))
        hit = i;
    end
    if (hit >= 0) begin
      chunks[hit].is_free = 1'b0;
      r.status       = ST_OK;
      r.chunk_offset = chunks[hit].off;
      r.class_index  = CLS_W'(best);
      return r;
    end
    // carve from the bump pointer
    lim   = (pool_bytes > POOL_CAP) ? AL_W'(POOL_CAP) : AL_W'(pool_bytes);
    step  = AL_W'(1) << align_log2;
    start = (AL_W'(bump) + step - AL_W'(1)) & ~(step - AL_W'(1));
    if (AL_W'(bump) >= lim || start + AL_W'(best_sz) > lim) begin
      r.status = ST_POOL_EXH;
    end else if (n_chunks >= DEPTH) begin
      r.status = ST_TABLE_FULL;
    end else begin
      chunks[n_chunks] = '{off: start[OFF_W-1:0], cls: CLS_W'(best), is_free: 1'b0};
      n_chunks++;
      bump           = SIZE_W'(start + AL_W'(best_sz));
      r.status       = ST_OK;
      r.chunk_offset = start[OFF_W-1:0];
      r.class_index  = CLS_W'(best);
    end
    return r;
  endfunction

  function void take_request(in_beat_t b);
    due_results.push_back(serve_request(b));
  endfunction

  task report(string msg);
    // print a bounded number of lines, count them all
    if (errors < 50) $display("ERROR @%0t: %s", $time, msg);
    errors++;
  endtask

  task check_result(out_beat_t got);
    out_beat_t want;
    if (due_results.size() == 0) begin
      report($sformatf("unexpected result st=%0d off=0x%0h cls=%0d",
                       got.status, got.chunk_offset, got.class_index));
      return;
    end
    want = due_results.pop_front();
    if (got.status !== want.status)
      report($sformatf("status %0d, want %0d", got.status, want.status));
    if (got.chunk_offset !== want.chunk_offset)
      report($sformatf("chunk_offset 0x%0h, want 0x%0h (status %0d)",
                       got.chunk_offset, want.chunk_offset, want.status));
    if (got.class_index !== want.class_index)
      report($sformatf("class_index %0d, want %0d (status %0d)",
                       got.class_index, want.class_index, want.status));
  endtask
endclass

module size_class_chunk_allocator_top_tb;

  localparam int TABLE_DEPTH    = 64;
  localparam int RAND_PER_PHASE = 275;
  localparam int HOLD_CYCLES    = 400;   // long receiver back-pressure stretch
  localparam int QUIET_LIMIT    = 3000;  // cycles with no beat on either channel

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  in_beat_t              in_data;
  logic                  out_valid;
  logic                  out_ready;
  out_beat_t             out_data;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  // idle rates in percent per cycle, changed between phases
  int send_idle_pct;
  int recv_idle_pct;
  bit hold_go;

  chunk_alloc_tracker #(TABLE_DEPTH) trk;

  size_class_chunk_allocator_top #(
    .MAX_ENTRIES(TABLE_DEPTH)
  ) u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always #1 clk = ~clk;

  // Result side: random stalls, plus one long hold-off once hold_go is raised.
  initial begin : result_sink
    bit hold_done;
    hold_done = 1'b0;
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_go && !hold_done) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Every accepted result beat is checked against the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) trk.check_result(out_data);
  end

  // Watchdog: ends the run if no beat moves for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
    end
    $display("** size_class_chunk_allocator_top: FAILED **");
    $finish;
  end

  // Offer one request beat, idling first at the sender's rate; the tracker
  // sees it at the edge where it is accepted.
  task automatic issue(in_beat_t b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    trk.take_request(b);
  endtask

  task automatic alloc_req(logic [SIZE_W-1:0] n);
    in_beat_t b;
    b.cmd         = CMD_ALLOC;
    b.req_bytes   = n;
    b.free_offset = OFF_W'($urandom);
    issue(b);
  endtask

  task automatic free_req(logic [OFF_W-1:0] off);
    in_beat_t b;
    b.cmd         = CMD_FREE;
    b.req_bytes   = SIZE_W'($urandom);
    b.free_offset = off;
    issue(b);
  endtask

  // Stop offering and wait until every expected result has come back.
  task automatic drain();
    in_valid <= 1'b0;
    while (trk.due_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    trk.set_reg(idx, val);
  endtask

  // Writes the whole register set; only called while the block is idle.
  task automatic configure(logic [SIZE_W-1:0] c0, logic [SIZE_W-1:0] c1,
                           logic [SIZE_W-1:0] c2, logic [SIZE_W-1:0] c3,
                           logic [ALIGN_W-1:0] al, logic [SIZE_W-1:0] pool);
    write_reg(REG_CLASS0, c0);
    write_reg(REG_CLASS1, c1);
    write_reg(REG_CLASS2, c2);
    write_reg(REG_CLASS3, c3);
    write_reg(REG_ALIGN, CFG_DATA_W'(al));
    write_reg(REG_POOL, pool);
    cfg_we <= 1'b0;
  endtask

  // Random request: mostly allocs sized around the live classes and frees of
  // recorded chunks (in use by preference), the rest raw noise.
  function automatic in_beat_t make_request(int alloc_pct, int free_pct);
    in_beat_t b;
    int       roll;
    int       k;
    int       pick;
    b.cmd         = CMD_ALLOC;
    b.req_bytes   = SIZE_W'($urandom);
    b.free_offset = OFF_W'($urandom);
    roll = $urandom_range(99);
    if (roll < alloc_pct) begin
      k = $urandom_range(NUM_CLASSES - 1);
      if (trk.class_size[k] != '0) begin
        case ($urandom_range(9))
          0:       b.req_bytes = trk.class_size[k];
          1:       b.req_bytes = trk.class_size[k] + 1'b1;
          default: b.req_bytes = SIZE_W'($urandom_range(trk.class_size[k]));
        endcase
      end
    end else if (roll < alloc_pct + free_pct && trk.n_chunks != 0) begin
      b.cmd = CMD_FREE;
      pick  = $urandom_range(trk.n_chunks - 1);
      if ($urandom_range(3) != 0) begin
        for (int t = 0; t < trk.n_chunks && trk.chunks[pick].is_free; t++)
          pick = (pick + 1) % trk.n_chunks;
      end
      b.free_offset = trk.chunks[pick].off;
    end else if ($urandom_range(1) == 1) begin
      b.cmd = CMD_FREE;  // random offset, almost always unknown
    end
    return b;
  endfunction

  initial begin : stimulus
    int                 alloc_pct;
    int                 free_pct;
    logic [SIZE_W-1:0]  c0, c1, c2, c3, pool;
    logic [ALIGN_W-1:0] al;

    trk       = new();
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_we    = 1'b0;
    cfg_index = REG_CLASS0;
    cfg_wdata = '0;
    hold_go   = 1'b0;
    send_idle_pct = 13;
    recv_idle_pct = 55;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Reset registers: every class unused, so nothing can be allocated.
    alloc_req('0);
    free_req('0);
    alloc_req(SIZE_W'(65536));
    drain();

    // Ascending classes, top class unused, no alignment, pool above the cap.
    configure(16, 64, 256, 0, 0, 17'h1FFFF);
    alloc_req(0);              // zero bytes still takes the smallest class
    alloc_req(16);             // exact fit
    alloc_req(17);
    alloc_req(256);
    alloc_req(257);            // larger than every class in use
    alloc_req(17'h1FFFF);
    free_req(16);
    free_req(0);
    alloc_req(5);              // two free chunks: the lower offset wins
    free_req(0);
    free_req(0);               // double free
    free_req(16'hFFFF);        // unknown offset
    drain();

    // Unordered classes with a tie, 4 KiB alignment, full-size class.
    configure(64, 16, 16, SIZE_W'(65536), 12, SIZE_W'(65536));
    alloc_req(10);             // tie between classes 1 and 2: lower index
    alloc_req(SIZE_W'(65536)); // aligned start pushes it past the pool end
    alloc_req(60);
    free_req(32);              // chunk keeps the class it was carved in
    drain();

    // Empty pool at the largest alignment, then alignment above 4 KiB.
    configure(64, 16, 16, SIZE_W'(65536), 15, 0);
    alloc_req(20);             // reuse still works with no pool left
    alloc_req(30);             // carve fails: bump already past the limit
    drain();
    configure(64, 16, 16, SIZE_W'(65536), 13, SIZE_W'(65536));
    alloc_req(30);
    drain();

    // Random phases: two per idle mode.
    for (int ph = 0; ph < 6; ph++) begin
      alloc_pct = 55;
      free_pct  = 35;
      case (ph)
        0: begin
          c0 = SIZE_W'($urandom_range(1, 64));
          c1 = SIZE_W'($urandom_range(65, 300));
          c2 = SIZE_W'($urandom_range(301, 1200));
          c3 = SIZE_W'($urandom_range(1201, 4000));
          al = ALIGN_W'($urandom_range(0, 4));
          configure(c0, c1, c2, c3, al, SIZE_W'(65536));
        end
        1: begin
          // duplicated and descending sizes, one class unused
          c0 = SIZE_W'($urandom_range(100, 800));
          c2 = SIZE_W'($urandom_range(1, 99));
          configure(c0, c0, c2, 0, 0, 17'h1FFFF);
        end
        2: begin
          send_idle_pct = 55;
          recv_idle_pct = 13;
          c0   = SIZE_W'($urandom_range(1, 128));
          c1   = SIZE_W'($urandom_range(129, 512));
          c2   = SIZE_W'($urandom_range(513, 2048));
          c3   = SIZE_W'($urandom_range(2049, 8192));
          pool = SIZE_W'($urandom_range(30000, 65536));
          al   = ALIGN_W'($urandom_range(5, 12));
          configure(c0, c1, c2, c3, al, pool);
        end
        3: begin
          c0 = SIZE_W'($urandom_range(1, 300));
          c1 = SIZE_W'($urandom_range(1, 300));
          c2 = SIZE_W'($urandom_range(301, 3000));
          c3 = $urandom_range(0, 1) ? SIZE_W'(65536) : SIZE_W'(0);
          configure(c0, c1, c2, c3, 15, SIZE_W'(65536));
        end
        4: begin
          // mostly allocs to fill the chunk table; long result hold-off
          send_idle_pct = 0;
          recv_idle_pct = 0;
          alloc_pct = 90;
          free_pct  = 5;
          configure(8, 24, 72, 200, 2, SIZE_W'(65536));
          hold_go <= 1'b1;
        end
        default: begin
          c0 = SIZE_W'($urandom_range(1, 512));
          c1 = SIZE_W'($urandom_range(1, 8192));
          c2 = SIZE_W'($urandom_range(0, 20000));
          al = ALIGN_W'($urandom_range(13, 14));
          configure(c0, c1, c2, SIZE_W'(65536), al, SIZE_W'(65536));
        end
      endcase
      repeat (RAND_PER_PHASE) issue(make_request(alloc_pct, free_pct));
      drain();
    end

    // quiet tail: anything arriving now is an unexpected result
    repeat (2 * (TABLE_DEPTH + 4)) @(posedge clk);
    if (trk.errors == 0) begin
      $display("** size_class_chunk_allocator_top: PASSED **");
    end else begin
      $display("** size_class_chunk_allocator_top: FAILED **");
    end
    $finish;
  end

endmodule

// ----- size_class_chunk_allocator_top.f -----
sv/scca_pkg.sv
sv/scca_class_sel.sv
sv/size_class_chunk_allocator_top.sv
sv/scca_checker.sv
dv/size_class_chunk_allocator_top_tb.sv
